FILE: src/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types, codes and the microcode program of the capture speed meter.
// ----------------------------------------------------------------------------
package csm_pkg;

   localparam int WINDOW_DEPTH_DEF = 10;

   // request action codes
   localparam logic [1:0] ACT_OVF  = 2'd0;
   localparam logic [1:0] ACT_CAP  = 2'd1;
   localparam logic [1:0] ACT_CALC = 2'd2;

   // motor direction codes
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_REV = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_TIMER_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OVF_LIMIT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_SCALE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_LOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_HIGH   = 3'd5;

   // configuration reset values
   localparam logic [15:0] TIMER_PERIOD_RST = 16'hFFFF;
   localparam logic [15:0] OVF_LIMIT_RST    = 16'd100;
   localparam logic [31:0] TIMEOUT_RST      = 32'hFFFF_FFFF;
   localparam logic [31:0] SPEED_SCALE_RST  = 32'd1000000;
   localparam logic [31:0] PERIOD_LOW_RST   = 32'd0;
   localparam logic [31:0] PERIOD_HIGH_RST  = 32'hFFFF_FFFF;

   localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NOP,
      OP_DIV_SPEED,
      OP_SPEED,
      OP_DIV_MEAN,
      OP_EMIT,
      OP_OVF,
      OP_CAP
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_REQ,
      C_IS_OVF,
      C_IS_CAP,
      C_NOT_CALC,
      C_DIV_BUSY,
      C_RSP_FULL
   } cond_type;

   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] STEP_WAIT      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DISP_OVF  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DISP_CAP  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DISP_CALC = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DIV_SPEED = 4'd4;
   localparam logic [STEP_W-1:0] STEP_WAIT_SPD  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SPEED     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DIV_MEAN  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_WAIT_MEAN = 4'd8;
   localparam logic [STEP_W-1:0] STEP_HOLD      = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd10;
   localparam logic [STEP_W-1:0] STEP_OVF       = 4'd11;
   localparam logic [STEP_W-1:0] STEP_CAP       = 4'd12;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } uword_type;

   // sequencer to datapath
   typedef struct packed {
      op_type op;
      logic   accept;
   } ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic [1:0] action;
      logic       div_busy;
      logic       rsp_full;
   } sts_type;

   // control store
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] addr);
      uword_type w;
      case (addr)
         STEP_WAIT:      w = '{OP_NOP,       C_NO_REQ,   STEP_WAIT};
         STEP_DISP_OVF:  w = '{OP_NOP,       C_IS_OVF,   STEP_OVF};
         STEP_DISP_CAP:  w = '{OP_NOP,       C_IS_CAP,   STEP_CAP};
         STEP_DISP_CALC: w = '{OP_NOP,       C_NOT_CALC, STEP_WAIT};
         STEP_DIV_SPEED: w = '{OP_DIV_SPEED, C_NEXT,     STEP_WAIT};
         STEP_WAIT_SPD:  w = '{OP_NOP,       C_DIV_BUSY, STEP_WAIT_SPD};
         STEP_SPEED:     w = '{OP_SPEED,     C_NEXT,     STEP_WAIT};
         STEP_DIV_MEAN:  w = '{OP_DIV_MEAN,  C_NEXT,     STEP_WAIT};
         STEP_WAIT_MEAN: w = '{OP_NOP,       C_DIV_BUSY, STEP_WAIT_MEAN};
         STEP_HOLD:      w = '{OP_NOP,       C_RSP_FULL, STEP_HOLD};
         STEP_EMIT:      w = '{OP_EMIT,      C_ALWAYS,   STEP_WAIT};
         STEP_OVF:       w = '{OP_OVF,       C_ALWAYS,   STEP_WAIT};
         STEP_CAP:       w = '{OP_CAP,       C_ALWAYS,   STEP_WAIT};
         default:        w = '{OP_NOP,       C_ALWAYS,   STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

FILE: src/csm_div.sv
// ----------------------------------------------------------------------------
// csm_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module csm_div #(
   parameter int DIVIDEND_W = 36
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [31:0]           divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEPS = (DIVIDEND_W + 1) / 2;
   localparam int Q_W   = 2 * STEPS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      divisor_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;

   // two dependent shift-subtract steps
   always_comb begin
      logic [32:0] trial;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int k = 0; k < 2; k++) begin
         trial  = {rem_in, quo_in[Q_W-1]};
         quo_in = {quo_in[Q_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial     = trial - {1'b0, divisor_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff    <= 1'b1;
         cnt_ff     <= CNT_W'(STEPS);
         quo_ff     <= Q_W'(dividend);
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff[DIVIDEND_W-1:0];

   a_start_sets_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not go busy after start");

   a_last_step_ends : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_W'(1)) |=> !busy_ff)
      else $error("divider ran past its last step");

endmodule

FILE: src/csm_dp.sv
// ----------------------------------------------------------------------------
// csm_dp
// Datapath: configuration, capture state, speed window, divider, result.
// ----------------------------------------------------------------------------
module csm_dp #(
   parameter int WINDOW_DEPTH = csm_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  csm_pkg::ctl_type                   ctl,
   output csm_pkg::sts_type                   sts,
   input  logic [1:0]                         req_action,
   input  logic                               req_has_capture,
   input  logic [15:0]                        req_capture_value,
   input  logic [1:0]                         req_motor_direction,
   input  logic [31:0]                        req_position,
   input  logic                               csr_write,
   input  logic [csm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                        csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [31:0]                 rsp_speed_avg
);

   localparam int SUM_W = 32 + $clog2(WINDOW_DEPTH);

   // configuration
   logic [15:0] timer_period_ff;
   logic [15:0] ovf_limit_ff;
   logic [31:0] timeout_ff;
   logic [31:0] speed_scale_ff;
   logic [31:0] period_low_ff;
   logic [31:0] period_high_ff;

   // latched request
   logic [1:0]  action_ff;
   logic        has_capture_ff;
   logic [15:0] capture_value_ff;
   logic [1:0]  direction_ff;
   logic [31:0] position_ff;

   // measurement state
   logic [15:0]        last_capture_ff;
   logic [15:0]        ovf_count_ff;
   logic [31:0]        period_ff;
   logic [31:0]        prev_position_ff;
   logic               in_range_ff;
   logic signed [31:0] window_ff [WINDOW_DEPTH];
   logic signed [SUM_W-1:0] sum_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_speed_avg_ff;

   // divider
   logic             div_start;
   logic [SUM_W-1:0] div_dividend;
   logic [31:0]      div_divisor;
   logic             div_busy;
   logic [SUM_W-1:0] div_quo;

   logic [15:0]        capture_new;
   logic [31:0]        ovf_product;
   logic [31:0]        period_cap;
   logic [31:0]        speed_mag;
   logic               negate;
   logic signed [31:0] speed;
   logic [SUM_W-1:0]   sum_abs;
   logic [31:0]        mean_mag;

   assign div_start    = (ctl.op == csm_pkg::OP_DIV_SPEED) || (ctl.op == csm_pkg::OP_DIV_MEAN);
   assign sum_abs      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_dividend = (ctl.op == csm_pkg::OP_DIV_MEAN) ? sum_abs : SUM_W'(speed_scale_ff);
   assign div_divisor  = (ctl.op == csm_pkg::OP_DIV_MEAN) ? 32'(WINDOW_DEPTH) : period_ff;

   csm_div #(
      .DIVIDEND_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // capture period: new + timer_period * overflows - old, mod 2^32
   assign capture_new = has_capture_ff ? capture_value_ff : last_capture_ff;
   assign ovf_product = 32'(timer_period_ff) * 32'(ovf_count_ff);
   assign period_cap  = 32'(capture_new) + ovf_product - 32'(last_capture_ff);

   // speed from quotient: zero when the period is out of range, else saturate, then apply direction sign
   always_comb begin
      if (!in_range_ff) begin
         speed_mag = '0;
      end else if (|div_quo[SUM_W-1:31]) begin
         speed_mag = csm_pkg::SPEED_MAX;
      end else begin
         speed_mag = div_quo[31:0];
      end
   end

   assign negate = ((direction_ff == csm_pkg::DIR_FWD) && (position_ff > prev_position_ff)) ||
                   ((direction_ff == csm_pkg::DIR_REV) && (position_ff < prev_position_ff));
   assign speed    = negate ? -$signed(speed_mag) : $signed(speed_mag);
   assign mean_mag = sum_ff[SUM_W-1] ? -div_quo[31:0] : div_quo[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_period_ff  <= csm_pkg::TIMER_PERIOD_RST;
         ovf_limit_ff     <= csm_pkg::OVF_LIMIT_RST;
         timeout_ff       <= csm_pkg::TIMEOUT_RST;
         speed_scale_ff   <= csm_pkg::SPEED_SCALE_RST;
         period_low_ff    <= csm_pkg::PERIOD_LOW_RST;
         period_high_ff   <= csm_pkg::PERIOD_HIGH_RST;
         last_capture_ff  <= '0;
         ovf_count_ff     <= '0;
         period_ff        <= '0;
         prev_position_ff <= '0;
         sum_ff           <= '0;
         in_range_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               csm_pkg::REG_TIMER_PERIOD: timer_period_ff <= csr_wdata[15:0];
               csm_pkg::REG_OVF_LIMIT:    ovf_limit_ff    <= csr_wdata[15:0];
               csm_pkg::REG_TIMEOUT:      timeout_ff      <= csr_wdata;
               csm_pkg::REG_SPEED_SCALE:  speed_scale_ff  <= csr_wdata;
               csm_pkg::REG_PERIOD_LOW:   period_low_ff   <= csr_wdata;
               csm_pkg::REG_PERIOD_HIGH:  period_high_ff  <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (ctl.op)
            csm_pkg::OP_OVF: begin
               if (ovf_count_ff < ovf_limit_ff) begin
                  ovf_count_ff <= ovf_count_ff + 16'd1;
               end else begin
                  ovf_count_ff <= ovf_limit_ff;
                  period_ff    <= timeout_ff;
               end
            end
            csm_pkg::OP_CAP: begin
               last_capture_ff <= capture_new;
               period_ff       <= period_cap;
               ovf_count_ff    <= '0;
            end
            csm_pkg::OP_DIV_SPEED: begin
               in_range_ff <= (period_ff > period_low_ff) && (period_ff < period_high_ff);
            end
            csm_pkg::OP_SPEED: begin
               prev_position_ff <= position_ff;
               for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                  window_ff[i] <= window_ff[i+1];
               end
               window_ff[WINDOW_DEPTH-1] <= speed;
               sum_ff <= sum_ff + SUM_W'(speed) - SUM_W'(window_ff[0]);
            end
            csm_pkg::OP_EMIT: begin
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // request fields and result payload carry no reset
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         action_ff        <= req_action;
         has_capture_ff   <= req_has_capture;
         capture_value_ff <= req_capture_value;
         direction_ff     <= req_motor_direction;
         position_ff      <= req_position;
      end
      if (ctl.op == csm_pkg::OP_EMIT) begin
         rsp_speed_avg_ff <= $signed(mean_mag);
      end
   end

   assign sts.action   = action_ff;
   assign sts.div_busy = div_busy;
   assign sts.rsp_full = rsp_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_avg = rsp_speed_avg_ff;

   a_emit_into_free_slot : assert property (@(posedge clock) disable iff (reset)
      (ctl.op == csm_pkg::OP_EMIT) |-> !rsp_valid_ff)
      else $error("result written over a pending response");

   a_valid_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.op == csm_pkg::OP_EMIT))
      else $error("response valid raised without an emit step");

   a_div_start_idle : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule

FILE: src/csm_seq.sv
// ----------------------------------------------------------------------------
// csm_seq
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// ----------------------------------------------------------------------------
module csm_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  csm_pkg::sts_type sts,
   output csm_pkg::ctl_type ctl
);

   logic [csm_pkg::STEP_W-1:0] step_ff, step_in;
   csm_pkg::uword_type         uword;
   logic                       take;

   assign uword = csm_pkg::ucode_rom(step_ff);

   always_comb begin
      case (uword.cond)
         csm_pkg::C_NEXT:     take = 1'b0;
         csm_pkg::C_ALWAYS:   take = 1'b1;
         csm_pkg::C_NO_REQ:   take = !req_valid;
         csm_pkg::C_IS_OVF:   take = (sts.action == csm_pkg::ACT_OVF);
         csm_pkg::C_IS_CAP:   take = (sts.action == csm_pkg::ACT_CAP);
         csm_pkg::C_NOT_CALC: take = (sts.action != csm_pkg::ACT_CALC);
         csm_pkg::C_DIV_BUSY: take = sts.div_busy;
         csm_pkg::C_RSP_FULL: take = sts.rsp_full;
         default:             take = 1'b0;
      endcase
      step_in = take ? uword.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= csm_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_stall  = (step_ff != csm_pkg::STEP_WAIT);
   assign ctl.op     = uword.op;
   assign ctl.accept = req_valid && !req_stall;

   a_accept_dispatches : assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> (step_ff == csm_pkg::STEP_DISP_OVF))
      else $error("accepted request did not reach dispatch");

endmodule

FILE: src/capture_speed_meter_signed_avg_core.sv
// ----------------------------------------------------------------------------
// capture_speed_meter_signed_avg_core
// Input-capture speed meter with a signed moving average of the speed.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| action, has_capture, capture_value,
//          |           |                    | motor_direction, position
//  rsp     | out       | rsp_valid/rsp_stall| speed_avg (signed, one per calculate)
//  csr     | in        | csr_write          | csr_index, csr_wdata (no read-back)
//
//  Overflow requests pass a dispatch step and the overflow step before the next
//  accept, capture requests two dispatch steps and the capture step, unused ones
//  three dispatch steps. A calculate runs the shared two-bit-per-cycle divider
//  twice, once for scale / period and once for the window mean.
//  A waiting result blocks no request; a calculate holds before emit until rsp is taken.
//  Reset is synchronous and active high and loads the register defaults.
// ----------------------------------------------------------------------------
module capture_speed_meter_signed_avg_core #(
   parameter int WINDOW_DEPTH = csm_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic                           req_has_capture,
   input  logic [15:0]                    req_capture_value,
   input  logic [1:0]                     req_motor_direction,
   input  logic [31:0]                    req_position,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_speed_avg,
   // register write port
   input  logic                           csr_write,
   input  logic [csm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata
);

   // control word out of the sequencer, status back from the datapath
   csm_pkg::ctl_type ctl;
   csm_pkg::sts_type sts;

   // step through the microcode program; ready only at the wait step
   csm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // hold configuration, measurement state, window and the result register
   csm_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .req_action          (req_action),
      .req_has_capture     (req_has_capture),
      .req_capture_value   (req_capture_value),
      .req_motor_direction (req_motor_direction),
      .req_position        (req_position),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_speed_avg       (rsp_speed_avg)
   );

endmodule
